### sv/tgfr_pkg.sv
// Shared types and codes for the timestamp gated frame ring.
`timescale 1ns / 1ps
package tgfr_pkg;

  localparam int unsigned SizeW  = 31;
  localparam int unsigned StampW = 32;
  localparam int unsigned SlotW  = 5;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    logic [SizeW-1:0]  size;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic             ok;
    logic [SlotW-1:0] slot;
    logic [SizeW-1:0] size;
    logic             not_full;
  } result_t;

endpackage

### sv/timestamp_gated_frame_ring_unit.sv
// Top level of the timestamp gated frame ring: slot RAM, control and result register.
// A result is registered and appears in the cycle after its word is accepted.
// Throughput: one word per cycle unless a held result stalls the input; the head slot
// is prefetched from the slot RAM, so a pop only compares against registered data.
// Reset: pointers return to write 0 / read SLOTS-1 and all slot valid bits clear,
// so every slot reads as zero; no clearing pass, the ring accepts at once.
`timescale 1ns / 1ps
module timestamp_gated_frame_ring_unit
  import tgfr_pkg::*;
#(
  parameter int unsigned SLOTS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               op_i,
  input  logic [SizeW-1:0]         frame_size_i,
  input  logic signed [StampW-1:0] time_stamp_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     ok_o,
  output logic [SlotW-1:0]         slot_o,
  output logic [SizeW-1:0]         size_out_o,
  output logic                     not_full_o
);

  localparam int unsigned PtrW = $clog2(SLOTS);

  logic            accept;
  logic            ram_we;
  logic [PtrW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rdata;
  result_t         res, res_q;
  logic            out_valid_q;

  // result register frees up when its word is taken in the same cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  tgfr_ram #(
    .Width($bits(entry_t)),
    .Depth(SLOTS),
    .AddrW(PtrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  tgfr_ctrl #(
    .Slots(SLOTS),
    .PtrW (PtrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .frame_size_i(frame_size_i),
    .time_stamp_i(time_stamp_i),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = res_q.ok;
  assign slot_o      = res_q.slot;
  assign size_out_o  = res_q.size;
  assign not_full_o  = res_q.not_full;

`ifndef SYNTHESIS
  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word produced no result");

  a_no_accept_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !accept)
    else $error("word accepted while result register is held");

  a_pending_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_q))
    else $error("held result lost or changed");
`endif

endmodule

### sv/tgfr_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module tgfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tgfr_ctrl.sv
// Ring pointers, slot valid bits, head prefetch and per-word decision.
`timescale 1ns / 1ps
module tgfr_ctrl
  import tgfr_pkg::*;
#(
  parameter int unsigned Slots = 32,
  parameter int unsigned PtrW  = $clog2(Slots)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [1:0]               op_i,
  input  logic [SizeW-1:0]         frame_size_i,
  input  logic signed [StampW-1:0] time_stamp_i,
  input  entry_t                   ram_rdata_i,
  output logic                     ram_we_o,
  output logic [PtrW-1:0]          ram_waddr_o,
  output entry_t                   ram_wdata_o,
  output logic [PtrW-1:0]          ram_raddr_o,
  output result_t                  res_o
);

  localparam logic [PtrW-1:0] LastPtr = PtrW'(Slots - 1);

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [Slots-1:0] valid_q, valid_d;
  logic            head_valid_q;
  logic            byp_q;
  entry_t          byp_data_q;
  entry_t          head;
  entry_t          wr_entry;
  logic [PtrW-1:0] nx;
  logic            push_ok, pop_ok;
  op_e             op;

  assign op = op_e'(op_i);
  assign nx = ring_next(rd_ptr_q);
  assign wr_entry = '{size: frame_size_i, stamp: time_stamp_i};

  // Head slot data: invalid slots read as zero, a write into the slot being
  // fetched in the same cycle is forwarded.
  always_comb begin
    if (!head_valid_q) begin
      head = '0;
    end else if (byp_q) begin
      head = byp_data_q;
    end else begin
      head = ram_rdata_i;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    valid_d  = valid_q;
    push_ok  = 1'b0;
    pop_ok   = 1'b0;
    res_o    = '0;
    if (accept_i) begin
      unique case (op)
        OP_PUSH: begin
          if (wr_ptr_q != rd_ptr_q) begin
            push_ok           = 1'b1;
            valid_d[wr_ptr_q] = 1'b1;
            wr_ptr_d          = ring_next(wr_ptr_q);
            res_o.ok          = 1'b1;
            res_o.slot        = SlotW'(wr_ptr_q);
          end
        end
        OP_POP: begin
          if (nx != wr_ptr_q && $signed(head.stamp) <= time_stamp_i) begin
            pop_ok     = 1'b1;
            rd_ptr_d   = nx;
            res_o.ok   = 1'b1;
            res_o.slot = SlotW'(nx);
            res_o.size = head.size;
          end
        end
        OP_FLUSH: begin
          wr_ptr_d = nx;
          res_o.ok = 1'b1;
        end
        OP_CLEAR: begin
          valid_d  = '0;
          res_o.ok = 1'b1;
        end
        default: ;
      endcase
    end
    res_o.not_full = (wr_ptr_d != rd_ptr_d);
  end

  assign ram_we_o    = push_ok;
  assign ram_waddr_o = wr_ptr_q;
  assign ram_wdata_o = wr_entry;
  // prefetch the slot that follows the next read pointer
  assign ram_raddr_o = ring_next(rd_ptr_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      rd_ptr_q     <= LastPtr;
      valid_q      <= '0;
      head_valid_q <= 1'b0;
      byp_q        <= 1'b0;
    end else begin
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      valid_q      <= valid_d;
      head_valid_q <= valid_d[ram_raddr_o];
      byp_q        <= push_ok && (wr_ptr_q == ram_raddr_o);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wr_entry;
  end

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q <= LastPtr) && (rd_ptr_q <= LastPtr))
    else $error("ring pointer out of range");

  a_flush_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (op_i == OP_FLUSH) |=> (wr_ptr_q != rd_ptr_q))
    else $error("ring full after flush");

  a_clear_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (op_i == OP_CLEAR) |=> (valid_q == '0))
    else $error("slot valid bits survive clear");

  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok |=> (rd_ptr_q == $past(nx)) && (wr_ptr_q == $past(wr_ptr_q)))
    else $error("pop did not advance read pointer alone");
`endif

endmodule

### bench/tgfr_ring_checker.sv
// Frame ring checker: watches both word channels, predicts each result and compares it.
`timescale 1ns / 1ps
module tgfr_ring_checker
  import tgfr_pkg::*;
#(
  parameter int unsigned SLOTS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               op_i,
  input  logic [SizeW-1:0]         frame_size_i,
  input  logic signed [StampW-1:0] time_stamp_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic                     ok_i,
  input  logic [SlotW-1:0]         slot_i,
  input  logic [SizeW-1:0]         size_out_i,
  input  logic                     not_full_i,
  output int                       fail_count_o,
  output int                       awaiting_o
);

  logic [SizeW-1:0]  size_mem  [SLOTS];
  logic [StampW-1:0] stamp_mem [SLOTS];
  int unsigned       wr_ptr;
  int unsigned       rd_ptr;
  result_t           awaited_results [$];
  int                fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] seen);
    $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, field, want, seen);
    fails++;
  endtask

  function automatic int unsigned ring_after(input int unsigned p);
    return (p == SLOTS - 1) ? 0 : p + 1;
  endfunction

  // Updates the shadow ring and returns the result the word should produce.
  function automatic result_t apply_frame_op(input op_e op, input logic [SizeW-1:0] sz,
                                             input logic [StampW-1:0] ts);
    result_t     r;
    int unsigned nx;
    r = '0;
    case (op)
      OP_PUSH: begin
        if (wr_ptr != rd_ptr) begin
          size_mem[wr_ptr]  = sz;
          stamp_mem[wr_ptr] = ts;
          r.ok   = 1'b1;
          r.slot = wr_ptr[SlotW-1:0];
          wr_ptr = ring_after(wr_ptr);
        end
      end
      OP_POP: begin
        nx = ring_after(rd_ptr);
        // head frame is released only once it is due (signed time compare)
        if (nx != wr_ptr && $signed(stamp_mem[nx]) <= $signed(ts)) begin
          r.ok   = 1'b1;
          r.slot = nx[SlotW-1:0];
          r.size = size_mem[nx];
          rd_ptr = nx;
        end
      end
      OP_FLUSH: begin
        wr_ptr = ring_after(rd_ptr);
        r.ok   = 1'b1;
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          size_mem[i]  = '0;
          stamp_mem[i] = '0;
        end
        r.ok = 1'b1;
      end
    endcase
    r.not_full = (wr_ptr != rd_ptr);
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        size_mem[i]  = '0;
        stamp_mem[i] = '0;
      end
      wr_ptr = 0;
      rd_ptr = SLOTS - 1;
      awaited_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        awaited_results.push_back(apply_frame_op(op_e'(op_i), frame_size_i, time_stamp_i));
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with none awaited", 64'd0, 64'd1);
        end else begin
          want = awaited_results.pop_front();
          if (want.ok !== ok_i) report_mismatch("ok", want.ok, ok_i);
          if (want.slot !== slot_i) report_mismatch("slot", want.slot, slot_i);
          if (want.size !== size_out_i) report_mismatch("size_out", want.size, size_out_i);
          if (want.not_full !== not_full_i)
            report_mismatch("not_full", want.not_full, not_full_i);
        end
      end
    end
    awaiting_o = awaited_results.size();
  end

endmodule

### bench/tb.sv
// Testbench top for the frame ring: clock, reset, word stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb;
  import tgfr_pkg::*;

  localparam int unsigned SLOTS      = 32;
  localparam int unsigned WordTarget = 1950;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               in_valid   = 1'b0;
  op_e                op_sel     = OP_PUSH;
  logic [SizeW-1:0]   frame_size = '0;
  logic [StampW-1:0]  time_stamp = '0;
  logic               out_stall  = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               ok;
  logic [SlotW-1:0]   slot;
  logic [SizeW-1:0]   size_out;
  logic               not_full;
  int                 fail_count;
  int                 awaiting;

  int unsigned        words_sent = 0;
  int unsigned        burst_left = 0;
  bit                 steady     = 1'b0;
  logic [StampW-1:0]  now_ts;

  always #5 clk_i = ~clk_i;

  timestamp_gated_frame_ring_unit #(.SLOTS(SLOTS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op_sel),
    .frame_size_i (frame_size),
    .time_stamp_i (time_stamp),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .ok_o         (ok),
    .slot_o       (slot),
    .size_out_o   (size_out),
    .not_full_o   (not_full)
  );

  tgfr_ring_checker #(.SLOTS(SLOTS)) ring_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op_sel),
    .frame_size_i (frame_size),
    .time_stamp_i (time_stamp),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .ok_i         (ok),
    .slot_i       (slot),
    .size_out_i   (size_out),
    .not_full_i   (not_full),
    .fail_count_o (fail_count),
    .awaiting_o   (awaiting)
  );

  // Called at a falling edge; returns at a falling edge after the word is taken and any random idle gap.
  task automatic send_word(input op_e op, input logic [SizeW-1:0] sz,
                           input logic [StampW-1:0] ts);
    int unsigned gap;
    in_valid   <= 1'b1;
    op_sel     <= op;
    frame_size <= sz;
    time_stamp <= ts;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = steady ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(0, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // stamp close to the running presentation time, so pops land on both sides of due
  function automatic logic [StampW-1:0] near_stamp(input logic [StampW-1:0] base);
    return base + $urandom_range(0, 80) - 20;
  endfunction

  function automatic logic [SizeW-1:0] rand_size();
    return SizeW'($urandom);
  endfunction

  initial begin
    int unsigned kind;
    int unsigned n;
    int unsigned pick;
    now_ts = $urandom;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty ring, field extremes, due / not due, flush and clear
    send_word(OP_POP,   '0,            32'h8000_0000);
    send_word(OP_PUSH,  31'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(OP_PUSH,  31'h0,         32'h8000_0000);
    send_word(OP_POP,   31'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_word(OP_POP,   '0,            32'h7FFF_FFFF);
    send_word(OP_POP,   '0,            32'h8000_0000);
    send_word(OP_POP,   '0,            32'h7FFF_FFFF);
    send_word(OP_PUSH,  31'h5555_5555, 32'hAAAA_AAAA);
    send_word(OP_PUSH,  31'h2AAA_AAAA, 32'h5555_5555);
    send_word(OP_FLUSH, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_POP,   '0,            32'h7FFF_FFFF);
    send_word(OP_PUSH,  31'd123,       32'hFFFF_FFFB);
    send_word(OP_CLEAR, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_POP,   '0,            32'hFFFF_FFFF);
    send_word(OP_POP,   '0,            32'h0);
    send_word(OP_CLEAR, '0,            '0);
    send_word(OP_FLUSH, '0,            '0);

    while (words_sent < WordTarget) begin
      kind   = $urandom_range(0, 9);
      steady = ($urandom_range(0, 3) == 0);
      n      = $urandom_range(8, 40);
      if ($urandom_range(0, 7) == 0) now_ts = $urandom;
      case (kind)
        0, 1, 2: begin
          // fill, often past full
          repeat (n) begin
            now_ts = now_ts + $urandom_range(0, 10);
            send_word(OP_PUSH, rand_size(), near_stamp(now_ts));
          end
        end
        3, 4: begin
          // drain as presentation time advances
          repeat (n) begin
            now_ts = now_ts + $urandom_range(0, 30);
            send_word(OP_POP, rand_size(), now_ts);
          end
        end
        5, 6, 7: begin
          // producer and consumer interleaved
          repeat (n) begin
            now_ts = now_ts + $urandom_range(0, 8);
            if ($urandom_range(0, 1) != 0) send_word(OP_PUSH, rand_size(), near_stamp(now_ts));
            else send_word(OP_POP, rand_size(), now_ts);
          end
        end
        8: begin
          repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) send_word(OP_PUSH, rand_size(), $urandom);
            else if (pick < 8) send_word(OP_POP, rand_size(), $urandom);
            else if (pick == 8) send_word(OP_FLUSH, rand_size(), $urandom);
            else send_word(OP_CLEAR, rand_size(), $urandom);
          end
        end
        default: begin
          if ($urandom_range(0, 1) != 0) send_word(OP_FLUSH, rand_size(), $urandom);
          else send_word(OP_CLEAR, rand_size(), $urandom);
          repeat (n / 4) send_word(OP_POP, rand_size(), near_stamp(now_ts));
        end
      endcase
    end

    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // receiver: stall patterns in segments, plus two long hold-offs while words keep coming
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned cyc;
    int unsigned holds;
    cyc   = 0;
    holds = 0;
    @(posedge rst_ni);
    forever begin
      if (holds < 2 && cyc >= 1500 * (holds + 1)) begin
        repeat (300) begin
          @(negedge clk_i);
          out_stall <= 1'b1;
          cyc++;
        end
        holds++;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        cyc++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ((cyc % 5) < 2);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
sv/tgfr_pkg.sv
sv/tgfr_ram.sv
sv/tgfr_ctrl.sv
sv/timestamp_gated_frame_ring_unit.sv
bench/tgfr_ring_checker.sv
bench/tb.sv
